// ----- rtl/http_request_line_uri_extract_assert.svh -----
// assertion macros for the request-line uri extractor
`ifndef HTTP_REQUEST_LINE_URI_EXTRACT_ASSERT_SVH
`define HTTP_REQUEST_LINE_URI_EXTRACT_ASSERT_SVH

// same-cycle implication, off during reset
`define HRLUE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrlue assertion failed");

// next-cycle implication, off during reset
`define HRLUE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrlue assertion failed");

`endif

// ----- rtl/hrlue_pkg.sv -----
// types and constants shared by the request-line uri extractor
package hrlue_pkg;

   localparam int FIELD_W = 12;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CASE_BIT = 8'h20;
   // lower-case letters, compared against a byte with the case bit forced
   localparam logic [7:0] CH_LC_G  = 8'h67;
   localparam logic [7:0] CH_LC_E  = 8'h65;
   localparam logic [7:0] CH_LC_T  = 8'h74;
   localparam logic [7:0] CH_LC_H  = 8'h68;
   localparam logic [7:0] CH_LC_P  = 8'h70;

   // positions inside "HTTP/d.d CR LF"
   localparam logic [3:0] TRL_H     = 4'd1;
   localparam logic [3:0] TRL_T1    = 4'd2;
   localparam logic [3:0] TRL_T2    = 4'd3;
   localparam logic [3:0] TRL_P     = 4'd4;
   localparam logic [3:0] TRL_SLASH = 4'd5;
   localparam logic [3:0] TRL_MAJOR = 4'd6;
   localparam logic [3:0] TRL_DOT   = 4'd7;
   localparam logic [3:0] TRL_MINOR = 4'd8;
   localparam logic [3:0] TRL_CR    = 4'd9;
   localparam logic [3:0] TRL_LF    = 4'd10;

   typedef struct packed {
      logic uri_char;
      logic space;
      logic digit;
      logic letter_h;
      logic letter_t;
      logic letter_p;
      logic slash;
      logic dot;
      logic cr;
      logic lf;
   } char_class_type;

endpackage

// ----- rtl/http_request_line_uri_extract.sv -----
// top level: locates the uri of an http get request line in a byte stream
//
//  channel | dir | tdata (low bit up)                        | tlast
//  req_    | in  | data_byte[7:0]                            | last_byte
//  rsp_    | out | uri_found, uri_offset[11:0], uri_length[11:0], zero pad | -
//
// one byte per cycle; the state update is a single pass from the port into the
// state registers, and the result is registered for the output side.
// a result appears the cycle after the last byte of a buffer is taken.
// req_tready drops only while a result waits and rsp_tready is low.
// reset is synchronous and clears the parser and the output valid.
module http_request_line_uri_extract #(
   parameter int MAX_LEN = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // uri_found, uri_offset[11:0], uri_length[11:0], pad
);

   localparam int POS_W = $clog2(MAX_LEN + 1);
   localparam int EXT_W = (POS_W > hrlue_pkg::FIELD_W) ? POS_W : hrlue_pkg::FIELD_W;

   localparam logic [2:0] PH_SEARCH = 3'd0;
   localparam logic [2:0] PH_URI    = 3'd1;
   localparam logic [2:0] PH_TRAIL  = 3'd2;
   localparam logic [2:0] PH_DONE   = 3'd3;
   localparam logic [2:0] PH_FAIL   = 3'd4;

   logic [POS_W-1:0]                  pos_ff, pos_in;
   logic [2:0]                        phase_ff, phase_in;
   logic [23:0]                       recent_ff, recent_in;
   logic [POS_W-1:0]                  start_ff, start_in;
   logic [hrlue_pkg::FIELD_W-1:0]     end_ff, end_in;
   logic [3:0]                        trail_ff, trail_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [31:0]                       rsp_data_ff, rsp_data_in;

   hrlue_pkg::char_class_type         cls;
   logic                              accept;
   logic                              get_seen;
   logic                              trail_ok;
   logic [3:0]                        trail_next;
   logic [EXT_W-1:0]                  pos_ext;
   logic [EXT_W-1:0]                  start_ext;
   logic [hrlue_pkg::FIELD_W-1:0]     uri_offset;
   logic [hrlue_pkg::FIELD_W-1:0]     uri_length;

   hrlue_char_class u_char_class (
      .char_byte  (req_tdata),
      .char_class (cls)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign get_seen =
      ((recent_ff[23:16] | hrlue_pkg::CASE_BIT) == hrlue_pkg::CH_LC_G) &&
      ((recent_ff[15:8]  | hrlue_pkg::CASE_BIT) == hrlue_pkg::CH_LC_E) &&
      ((recent_ff[7:0]   | hrlue_pkg::CASE_BIT) == hrlue_pkg::CH_LC_T);

   assign trail_next = trail_ff + 4'd1;
   assign pos_ext    = EXT_W'(pos_ff);

   always_comb begin
      unique case (trail_next)
         hrlue_pkg::TRL_H:     trail_ok = cls.letter_h;
         hrlue_pkg::TRL_T1:    trail_ok = cls.letter_t;
         hrlue_pkg::TRL_T2:    trail_ok = cls.letter_t;
         hrlue_pkg::TRL_P:     trail_ok = cls.letter_p;
         hrlue_pkg::TRL_SLASH: trail_ok = cls.slash;
         hrlue_pkg::TRL_MAJOR: trail_ok = cls.digit;
         hrlue_pkg::TRL_DOT:   trail_ok = cls.dot;
         hrlue_pkg::TRL_MINOR: trail_ok = cls.digit;
         hrlue_pkg::TRL_CR:    trail_ok = cls.cr;
         hrlue_pkg::TRL_LF:    trail_ok = cls.lf;
         default:              trail_ok = 1'b0;
      endcase
   end

   // parser state update for the byte on the port
   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      recent_in = recent_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      trail_in  = trail_ff;
      if (pos_ff >= POS_W'(MAX_LEN)) begin
         // overlong buffer
         phase_in = PH_FAIL;
      end else begin
         pos_in    = pos_ff + POS_W'(1);
         recent_in = {recent_ff[15:0], req_tdata};
         unique case (phase_ff)
            PH_SEARCH: begin
               if (cls.space && get_seen) begin
                  phase_in = PH_URI;
                  start_in = pos_ff + POS_W'(1);
               end
            end
            PH_URI: begin
               if (cls.uri_char) begin
                  phase_in = PH_URI;
               end else if (cls.space && (pos_ff != start_ff)) begin
                  end_in   = pos_ext[hrlue_pkg::FIELD_W-1:0];
                  trail_in = 4'd0;
                  phase_in = PH_TRAIL;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_TRAIL: begin
               trail_in = trail_next;
               if (!trail_ok) begin
                  phase_in = PH_FAIL;
               end else if (trail_next == hrlue_pkg::TRL_LF) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   assign start_ext  = EXT_W'(start_in);
   assign uri_offset = start_ext[hrlue_pkg::FIELD_W-1:0];
   assign uri_length = end_in - uri_offset;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept && req_tlast) begin
         rsp_valid_in = 1'b1;
         if (phase_in == PH_DONE) begin
            rsp_data_in = {7'd0, uri_length, uri_offset, 1'b1};
         end else begin
            rsp_data_in = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= PH_SEARCH;
         recent_ff    <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         trail_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_tlast) begin
               // buffer ends: start clean for the next one
               pos_ff    <= '0;
               phase_ff  <= PH_SEARCH;
               recent_ff <= '0;
               start_ff  <= '0;
               end_ff    <= '0;
               trail_ff  <= '0;
            end else begin
               pos_ff    <= pos_in;
               phase_ff  <= phase_in;
               recent_ff <= recent_in;
               start_ff  <= start_in;
               end_ff    <= end_in;
               trail_ff  <= trail_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`include "http_request_line_uri_extract_assert.svh"

   `HRLUE_ASSERT_NOW(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `HRLUE_ASSERT_NEXT(a_last_gives_result, clock, reset, accept && req_tlast, rsp_tvalid)
   `HRLUE_ASSERT_NOW(a_miss_is_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata == 32'd0)
   `HRLUE_ASSERT_NEXT(a_last_clears, clock, reset, accept && req_tlast, pos_ff == '0 && phase_ff == PH_SEARCH)

endmodule

// ----- rtl/hrlue_char_class.sv -----
// classifies one request byte for the uri and trailer checks
module hrlue_char_class (
   input  logic [7:0]                  char_byte,
   output hrlue_pkg::char_class_type   char_class
);

   logic [7:0] folded;
   logic       letter;
   logic       digit;
   logic       punct;

   assign folded = char_byte | hrlue_pkg::CASE_BIT;
   assign letter = (folded >= "a") && (folded <= "z");
   assign digit  = (char_byte >= "0") && (char_byte <= "9");

   always_comb begin
      unique case (char_byte)
         hrlue_pkg::CH_PCT, "-", hrlue_pkg::CH_DOT, "_", hrlue_pkg::CH_TILDE, ":",
         hrlue_pkg::CH_SLASH, "?", "#", "[", "]", "@", "!", "$", "&", "'", "(", ")",
         "*", "+", ",", ";", "=": punct = 1'b1;
         default: punct = 1'b0;
      endcase
   end

   always_comb begin
      char_class.uri_char = letter || digit || punct;
      char_class.space    = (char_byte == hrlue_pkg::CH_SPACE);
      char_class.digit    = digit;
      char_class.letter_h = (folded == hrlue_pkg::CH_LC_H);
      char_class.letter_t = (folded == hrlue_pkg::CH_LC_T);
      char_class.letter_p = (folded == hrlue_pkg::CH_LC_P);
      char_class.slash    = (char_byte == hrlue_pkg::CH_SLASH);
      char_class.dot      = (char_byte == hrlue_pkg::CH_DOT);
      char_class.cr       = (char_byte == hrlue_pkg::CH_CR);
      char_class.lf       = (char_byte == hrlue_pkg::CH_LF);
   end

endmodule

// ----- dv/http_request_line_uri_extract_tb.sv -----
// self-checking testbench for the http request-line uri extractor
module http_request_line_uri_extract_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LINE_MAX     = 4096;
   localparam int unsigned RANDOM_BYTES = 1200;
   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int          MAX_SHOWN    = 10;

   typedef enum logic [2:0] {SEEK_GET, IN_URI, IN_VERSION, LINE_OK, LINE_BAD} line_phase_type;
   typedef enum logic [1:0] {RDY_ALWAYS, RDY_MASK, RDY_SPARSE, RDY_COIN} ready_style_type;

   typedef struct packed {
      logic                          found;
      logic [hrlue_pkg::FIELD_W-1:0] offset;
      logic [hrlue_pkg::FIELD_W-1:0] length;
   } uri_report_type;

   typedef struct packed {
      logic           pinned;
      uri_report_type want;
   } fixed_report_type;

   typedef struct {
      string          text;
      bit             pinned;
      uri_report_type want;
   } line_row_type;

   localparam uri_report_type NO_URI = '0;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // data_byte[7:0]
   logic        req_tlast  = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // uri_found, uri_offset[11:0], uri_length[11:0], pad

   always #5 clock = ~clock;

   http_request_line_uri_extract #(
      .MAX_LEN(LINE_MAX)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // parser state mirrored by the predictor
   int unsigned    line_pos    = 0;
   line_phase_type line_phase  = SEEK_GET;
   logic [23:0]    prev_bytes  = '0;
   int unsigned    uri_begin   = 0;
   int unsigned    uri_end     = 0;
   logic [3:0]     version_idx = '0;

   uri_report_type   pending_reports[$];
   fixed_report_type fixed_reports[$];
   logic [7:0]       line_bytes[$];

   string uri_chars =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~:/?#[]@!$&'()*+,;=%";

   line_row_type line_rows [16] = '{
      '{"GET / HTTP/1.1\015\n", 1'b1, '{1'b1, 12'd4, 12'd1}},
      '{"get /Index.html?a=1 hTtP/0.9\015\n", 1'b0, NO_URI},
      '{"GET  HTTP/1.1\015\n", 1'b1, NO_URI},
      '{"xxGET ", 1'b1, NO_URI},
      '{"GET /a HTTP/1.1\015", 1'b1, NO_URI},
      '{"GET /a HTTP/1.1\015\nextra", 1'b1, '{1'b1, 12'd4, 12'd2}},
      '{"POST /x HTTP/1.1\015\n GET /y HTTP/1.1\015\n", 1'b0, NO_URI},
      '{"GET /a\tHTTP/1.1\015\n", 1'b1, NO_URI},
      '{"GET /a HTTP/x.1\015\n", 1'b1, NO_URI},
      '{"GET /a HTTP/1.1\n", 1'b1, NO_URI},
      '{"GET /bad\"uri HTTP/1.1\015\n", 1'b1, NO_URI},
      '{"GET /all-._~:/?#[]@!$&'()*+,;=%AZaz09 HTTP/9.0\015\n", 1'b0, NO_URI},
      '{"G", 1'b1, NO_URI},
      '{"GET /a HTTP/1.1\015\nGET /b HTTP/1.1\015\n", 1'b1, '{1'b1, 12'd4, 12'd2}},
      '{"GETGET /x HTTP/1.1\015\n", 1'b0, NO_URI},
      '{"\377GET /q HTTP/1.1\015\n", 1'b0, NO_URI}
   };

   int fail_count   = 0;
   int shown_count  = 0;
   int lines_sent   = 0;
   int bytes_seen   = 0;
   int reports_seen = 0;
   int uris_seen    = 0;

   int unsigned     idle_cycles = 0;
   int unsigned     burst_left  = 0;
   bit              gaps_on     = 1'b1;
   int unsigned     ready_left  = 0;
   logic [3:0]      ready_tick  = '0;
   logic [15:0]     ready_mask  = '1;
   ready_style_type ready_style = RDY_ALWAYS;

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // advances the parser by one byte; returns 1 when the byte closes a buffer
   function automatic bit parse_request_byte(input logic [7:0] c, input logic last,
                                             output uri_report_type rep);
      int unsigned pos;
      bit          uri_char;
      bit          step_ok;
      logic [31:0] span;
      pos = line_pos;
      rep = NO_URI;
      if (pos >= LINE_MAX) begin
         line_phase = LINE_BAD;
      end else begin
         line_pos = pos + 1;
         case (line_phase)
            SEEK_GET: begin
               if (c == hrlue_pkg::CH_SPACE &&
                   (prev_bytes[23:16] | hrlue_pkg::CASE_BIT) == hrlue_pkg::CH_LC_G &&
                   (prev_bytes[15:8] | hrlue_pkg::CASE_BIT) == hrlue_pkg::CH_LC_E &&
                   (prev_bytes[7:0] | hrlue_pkg::CASE_BIT) == hrlue_pkg::CH_LC_T) begin
                  line_phase = IN_URI;
                  uri_begin  = pos + 1;
               end
            end
            IN_URI: begin
               case (c)
                  "%", "-", ".", "_", "~", ":", "/", "?", "#", "[", "]", "@", "!", "$",
                  "&", "'", "(", ")", "*", "+", ",", ";", "=": uri_char = 1'b1;
                  default: uri_char = is_digit(c) || (c >= "a" && c <= "z") ||
                                      (c >= "A" && c <= "Z");
               endcase
               if (!uri_char) begin
                  // the closing space may not be the first uri byte
                  if (c == hrlue_pkg::CH_SPACE && pos != uri_begin) begin
                     uri_end     = pos;
                     version_idx = '0;
                     line_phase  = IN_VERSION;
                  end else begin
                     line_phase = LINE_BAD;
                  end
               end
            end
            IN_VERSION: begin
               version_idx++;
               case (version_idx)
                  hrlue_pkg::TRL_H:
                     step_ok = (c | hrlue_pkg::CASE_BIT) == hrlue_pkg::CH_LC_H;
                  hrlue_pkg::TRL_T1, hrlue_pkg::TRL_T2:
                     step_ok = (c | hrlue_pkg::CASE_BIT) == hrlue_pkg::CH_LC_T;
                  hrlue_pkg::TRL_P:
                     step_ok = (c | hrlue_pkg::CASE_BIT) == hrlue_pkg::CH_LC_P;
                  hrlue_pkg::TRL_SLASH:  step_ok = c == hrlue_pkg::CH_SLASH;
                  hrlue_pkg::TRL_MAJOR, hrlue_pkg::TRL_MINOR: step_ok = is_digit(c);
                  hrlue_pkg::TRL_DOT:    step_ok = c == hrlue_pkg::CH_DOT;
                  hrlue_pkg::TRL_CR:     step_ok = c == hrlue_pkg::CH_CR;
                  hrlue_pkg::TRL_LF:     step_ok = c == hrlue_pkg::CH_LF;
                  default:               step_ok = 1'b0;
               endcase
               if (!step_ok) begin
                  line_phase = LINE_BAD;
               end else if (version_idx == hrlue_pkg::TRL_LF) begin
                  line_phase = LINE_OK;
               end
            end
            default: ;
         endcase
         prev_bytes = {prev_bytes[15:0], c};
      end
      if (!last) begin
         return 1'b0;
      end
      if (line_phase == LINE_OK) begin
         span       = uri_end - uri_begin;
         rep.found  = 1'b1;
         rep.offset = uri_begin[hrlue_pkg::FIELD_W-1:0];
         rep.length = span[hrlue_pkg::FIELD_W-1:0];
      end
      line_pos    = 0;
      line_phase  = SEEK_GET;
      prev_bytes  = '0;
      uri_begin   = 0;
      uri_end     = 0;
      version_idx = '0;
      return 1'b1;
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         line_bytes.push_back(s[i]);
      end
   endtask

   // letters come out in either case, other bytes are left alone by the case bit
   task automatic push_mixed_case(input string s);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if ($urandom_range(0, 1) != 0) begin
            c = c | hrlue_pkg::CASE_BIT;
         end
         line_bytes.push_back(c);
      end
   endtask

   // drives line_bytes as one buffer, in bursts on the request side, with gaps between them when gaps_on is set
   task automatic send_line(input logic pinned, input uri_report_type want);
      fixed_report_type fix;
      fix.pinned = pinned;
      fix.want   = want;
      fixed_reports.push_back(fix);
      foreach (line_bytes[i]) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            if (gaps_on) begin
               @(negedge clock) req_tvalid <= 1'b0;
               repeat ($urandom_range(0, 7)) @(negedge clock);
            end
         end
         burst_left--;
         @(negedge clock);
         req_tvalid <= 1'b1;
         req_tdata  <= line_bytes[i];
         req_tlast  <= (i == line_bytes.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      lines_sent++;
   endtask

   task automatic settle_lines();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   // receiver: switches at random between stall styles
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_style = ready_style_type'($urandom_range(0, 3));
         ready_mask  = 16'($urandom);
         ready_left  = $urandom_range(20, 300);
      end
      ready_left--;
      ready_tick++;
      case (ready_style)
         RDY_ALWAYS: rsp_tready <= 1'b1;
         RDY_MASK:   rsp_tready <= ready_mask[ready_tick];
         RDY_SPARSE: rsp_tready <= ($urandom_range(0, 5) == 0);
         default:    rsp_tready <= ($urandom_range(0, 1) != 0);
      endcase
   end

   always @(posedge clock) begin
      uri_report_type   rep;
      uri_report_type   want;
      uri_report_type   got;
      fixed_report_type fix;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            bytes_seen++;
            if (parse_request_byte(req_tdata, req_tlast, rep)) begin
               fix = fixed_reports.pop_front();
               pending_reports.push_back(fix.pinned ? fix.want : rep);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.found  = rsp_tdata[0];
            got.offset = rsp_tdata[12:1];
            got.length = rsp_tdata[24:13];
            reports_seen++;
            if (got.found) begin
               uris_seen++;
            end
            if (pending_reports.size() == 0) begin
               fail_count++;
               if (shown_count < MAX_SHOWN) begin
                  shown_count++;
                  $display("unexpected result: found=%0d offset=%0d length=%0d",
                           got.found, got.offset, got.length);
               end
            end else begin
               want = pending_reports.pop_front();
               if (got.found !== want.found || got.offset !== want.offset ||
                   got.length !== want.length) begin
                  fail_count++;
                  if (shown_count < MAX_SHOWN) begin
                     shown_count++;
                     // values are found/offset/length
                     $display("result %0d expected %0d/%0d/%0d actual %0d/%0d/%0d",
                              reports_seen, want.found, want.offset, want.length,
                              got.found, got.offset, got.length);
                  end
               end
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned random_bytes;
      int unsigned lines_in_phase;
      int unsigned pick;
      int unsigned n;
      random_bytes   = 0;
      lines_in_phase = 0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (line_rows[i]) begin
         line_bytes.delete();
         push_text(line_rows[i].text);
         send_line(line_rows[i].pinned, line_rows[i].want);
      end
      settle_lines();

      while (random_bytes < RANDOM_BYTES) begin
         if (lines_in_phase == 12) begin
            settle_lines();
            gaps_on        = ($urandom_range(0, 3) != 0);
            lines_in_phase = 0;
         end
         line_bytes.delete();
         pick = $urandom_range(0, 99);
         if (pick >= 85 && pick < 95) begin
            // plain noise
            repeat ($urandom_range(1, 40)) line_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            push_mixed_case("GET ");
            // 95 and up: the method space closes the buffer
            if (pick < 95) begin
               if (pick >= 80) begin
                  n = 0;
               end else if ($urandom_range(0, 15) == 0) begin
                  n = $urandom_range(25, 200);
               end else begin
                  n = $urandom_range(1, 24);
               end
               repeat (n) line_bytes.push_back(uri_chars[$urandom_range(0, uri_chars.len() - 1)]);
               line_bytes.push_back(hrlue_pkg::CH_SPACE);
               push_mixed_case("HTTP/");
               line_bytes.push_back(8'("0") + 8'($urandom_range(0, 9)));
               line_bytes.push_back(hrlue_pkg::CH_DOT);
               line_bytes.push_back(8'("0") + 8'($urandom_range(0, 9)));
               line_bytes.push_back(hrlue_pkg::CH_CR);
               line_bytes.push_back(hrlue_pkg::CH_LF);
               if ($urandom_range(0, 4) == 0) begin
                  repeat ($urandom_range(1, 5)) line_bytes.push_back(8'($urandom_range(0, 255)));
               end
               if (pick >= 50 && pick < 65) begin
                  line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
               end else if (pick >= 65 && pick < 80) begin
                  n = $urandom_range(1, line_bytes.size());
                  while (line_bytes.size() > n) void'(line_bytes.pop_back());
               end
            end
         end
         random_bytes += line_bytes.size();
         send_line(1'b0, NO_URI);
         lines_in_phase++;
      end

      settle_lines();
      repeat (12) @(posedge clock);
      if (pending_reports.size() != 0) begin
         fail_count += pending_reports.size();
         $display("%0d expected results never arrived", pending_reports.size());
      end
      $display("%0d buffers, %0d bytes taken, %0d results checked, %0d with a uri located",
               lines_sent, bytes_seen, reports_seen, uris_seen);
      $display("mix: clean, damaged, cut-short, empty-uri and noise buffers");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
